// ===== hw/rtl/coe_pkg.sv =====
`timescale 1ns / 1ps

package coe_pkg;

  // Field widths of the stream payloads
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned NOW_W      = 48;
  localparam int unsigned RTT_W      = 20;
  localparam int unsigned TS_W       = 31;
  localparam int unsigned RES_W      = 49;
  localparam int unsigned CNT_OUT_W  = 4;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 128;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - (RES_W + RTT_W + RES_W + CNT_OUT_W);

  // Working accumulator: holds (ts + avg) * 1000 and the differences built on it
  localparam int unsigned ACC_W = 62;

  // Quotient digit width of the divider (radix 16)
  localparam int unsigned DIG_W = 4;

  // Saturation bounds of a result, at accumulator width
  localparam logic signed [ACC_W-1:0] RES_MAX_ACC =
    {{(ACC_W-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] RES_MIN_ACC = ~RES_MAX_ACC;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE    = 2'd0,
    REQ_ADJ_TS    = 2'd1,
    REQ_ADJ_DELTA = 2'd2
  } req_e;

  // Datapath operation of one microcode step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LD_TS,
    OP_ADD_AVGD,
    OP_MUL1000,
    OP_SUB_NOW,
    OP_SUB_HALF,
    OP_RD_OLD,
    OP_DROP_OLD,
    OP_PUSH,
    OP_DIV_LD,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_CLR,
    OP_RES,
    OP_OUT
  } step_op_e;

  // Jump condition of one microcode step
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_SAMPLE,
    JC_UNUSED,
    JC_ADJ_TS,
    JC_ADJ_DELTA,
    JC_DIV_MORE,
    JC_OUT_BUSY
  } jump_e;

  localparam int unsigned PC_W     = 4;
  localparam int unsigned PROG_LEN = 16;

  typedef struct packed {
    step_op_e        op;
    jump_e           jc;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // Program addresses that are jumped to
  localparam logic [PC_W-1:0] PC_ENTRY    = 4'd0;
  localparam logic [PC_W-1:0] PC_MUL      = 4'd3;
  localparam logic [PC_W-1:0] PC_DIV_STEP = 4'd10;
  localparam logic [PC_W-1:0] PC_CLR      = 4'd12;
  localparam logic [PC_W-1:0] PC_RES      = 4'd13;
  localparam logic [PC_W-1:0] PC_OUT      = 4'd14;
  localparam logic [PC_W-1:0] PC_IDLE     = 4'd15;

  // Control store
  localparam ctrl_word_t PROG [PROG_LEN] = '{
    '{OP_LD_TS,    JC_SAMPLE,    PC_MUL},       // 0: load ts, samples skip the average
    '{OP_NONE,     JC_UNUSED,    PC_CLR},       // 1: unknown kind gives zero
    '{OP_ADD_AVGD, JC_ADJ_TS,    PC_RES},       // 2: ts + average delta
    '{OP_MUL1000,  JC_NEXT,      PC_ENTRY},     // 3: to milliseconds
    '{OP_SUB_NOW,  JC_NEXT,      PC_ENTRY},     // 4: now - acc
    '{OP_SUB_HALF, JC_ADJ_DELTA, PC_RES},       // 5: minus half round trip
    '{OP_RD_OLD,   JC_NEXT,      PC_ENTRY},     // 6: fetch oldest entries
    '{OP_DROP_OLD, JC_NEXT,      PC_ENTRY},     // 7: remove them from the sums
    '{OP_PUSH,     JC_NEXT,      PC_ENTRY},     // 8: store new entries
    '{OP_DIV_LD,   JC_NEXT,      PC_ENTRY},     // 9: set up divider
    '{OP_DIV_STEP, JC_DIV_MORE,  PC_DIV_STEP},  // 10: one quotient digit
    '{OP_DIV_END,  JC_ALWAYS,    PC_RES},       // 11: store averages
    '{OP_CLR,      JC_NEXT,      PC_ENTRY},     // 12: zero result
    '{OP_RES,      JC_NEXT,      PC_ENTRY},     // 13: saturate result
    '{OP_OUT,      JC_OUT_BUSY,  PC_OUT},       // 14: hand over to output
    '{OP_NONE,     JC_ALWAYS,    PC_IDLE}       // 15: wait for a request
  };

endpackage

// ===== hw/rtl/clock_offset_window_estimator.sv =====
`timescale 1ns / 1ps
// Ping samples run the radix-16 divider loop to update the window averages; timestamp
// queries, adjusted delta queries and unknown kinds skip it. One request at a time: the next
// one is taken in the cycle after its result is loaded into the output register.
// Reset (async, active low) empties both windows, zeroes sums and averages, clears tvalid.
module clock_offset_window_estimator #(
  parameter int unsigned DELTA_DEPTH = 10,
  parameter int unsigned RTT_DEPTH   = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [47:0] now_ms, [67:48] response_time_ms, [98:68] timestamp_s, [103:99] zero
  input  logic [coe_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] req_type
  input  logic [coe_pkg::REQ_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [48:0] result_value, [68:49] avg_response_ms, [117:69] avg_delta_ms,
  // [121:118] entries_held, [127:122] zero
  output logic [coe_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned DCW        = $clog2(DELTA_DEPTH + 1);
  localparam int unsigned RCW        = $clog2(RTT_DEPTH + 1);
  localparam int unsigned DAW        = (DELTA_DEPTH > 1) ? $clog2(DELTA_DEPTH) : 1;
  localparam int unsigned RAW        = (RTT_DEPTH > 1) ? $clog2(RTT_DEPTH) : 1;
  localparam int unsigned DSUM_W     = coe_pkg::RES_W + DCW;
  localparam int unsigned RSUM_W     = coe_pkg::RTT_W + RCW;
  localparam int unsigned DIV_DIGITS = (DSUM_W + coe_pkg::DIG_W - 1) / coe_pkg::DIG_W;
  localparam int unsigned DIV_W      = DIV_DIGITS * coe_pkg::DIG_W;
  localparam int unsigned CW         = (DCW > RCW) ? DCW : RCW;
  localparam int unsigned ITW        = $clog2(DIV_DIGITS);

  // One radix-16 digit of restoring division: returns {remainder, digit}
  function automatic logic [CW+coe_pkg::DIG_W-1:0] div_digit(
    input logic [CW-1:0]              rem,
    input logic [coe_pkg::DIG_W-1:0]  dig,
    input logic [CW-1:0]              dvs
  );
    logic [CW:0]               r;
    logic [CW-1:0]             cur;
    logic [coe_pkg::DIG_W-1:0] q;
    int                        i;
    cur = rem;
    q   = '0;
    for (i = coe_pkg::DIG_W - 1; i >= 0; i--) begin
      r = {cur, dig[i]};
      if (r >= {1'b0, dvs}) begin
        r    = r - {1'b0, dvs};
        q[i] = 1'b1;
      end
      cur = r[CW-1:0];
    end
    return {cur, q};
  endfunction

  // Sequencer
  logic [coe_pkg::PC_W-1:0] pc_q, pc_d;
  coe_pkg::ctrl_word_t      ctrl;
  logic                     take_jump;
  logic                     in_acc;

  // Captured request
  logic [coe_pkg::REQ_W-1:0] req_q;
  logic [coe_pkg::NOW_W-1:0] now_q;
  logic [coe_pkg::RTT_W-1:0] rtt_in_q;
  logic [coe_pkg::TS_W-1:0]  ts_q;

  // Datapath
  logic signed [coe_pkg::ACC_W-1:0] acc_q, acc_d;
  logic signed [coe_pkg::RES_W-1:0] res_q, res_d;
  logic [coe_pkg::RTT_W-2:0]        half_rtt;

  // Windows and their running sums
  logic [coe_pkg::RTT_W-1:0]        rtt_mem [RTT_DEPTH];
  logic signed [coe_pkg::RES_W-1:0] delta_mem [DELTA_DEPTH];
  logic [coe_pkg::RTT_W-1:0]        rtt_old_q;
  logic signed [coe_pkg::RES_W-1:0] delta_old_q;
  logic [RAW-1:0]                   rtt_slot_q, rtt_slot_d;
  logic [DAW-1:0]                   delta_slot_q, delta_slot_d;
  logic [RCW-1:0]                   rtt_cnt_q, rtt_cnt_d;
  logic [DCW-1:0]                   delta_cnt_q, delta_cnt_d;
  logic                             rtt_full, delta_full;
  logic [RSUM_W-1:0]                rtt_sum_q, rtt_sum_d;
  logic signed [DSUM_W-1:0]         delta_sum_q, delta_sum_d;
  logic [DSUM_W-1:0]                delta_mag;

  // Averages
  logic [coe_pkg::RTT_W-1:0]        avg_rtt_q, avg_rtt_d;
  logic signed [coe_pkg::RES_W-1:0] avg_delta_q, avg_delta_d;

  // Divider lanes
  logic [DIV_W-1:0]                dq_q, dq_d, rq_q, rq_d, dq_neg;
  logic [CW-1:0]                   dr_q, dr_d, rr_q, rr_d;
  logic                            dneg_q, dneg_d;
  logic [ITW-1:0]                  it_q, it_d;
  logic [CW+coe_pkg::DIG_W-1:0]    d_step, r_step;

  // Output register
  logic                            m_valid_q, m_valid_d;
  logic [coe_pkg::OUT_DATA_W-1:0]  m_data_q, m_data_d;
  logic                            out_busy;

  assign ctrl          = coe_pkg::PROG[pc_q];
  assign s_axis_tready = (pc_q == coe_pkg::PC_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_busy      = m_valid_q && !m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign rtt_full   = (rtt_cnt_q == RCW'(RTT_DEPTH));
  assign delta_full = (delta_cnt_q == DCW'(DELTA_DEPTH));
  assign half_rtt   = (req_q == coe_pkg::REQ_SAMPLE) ? rtt_in_q[coe_pkg::RTT_W-1:1]
                                                     : avg_rtt_q[coe_pkg::RTT_W-1:1];
  assign delta_mag  = delta_sum_q[DSUM_W-1] ? DSUM_W'(-delta_sum_q) : DSUM_W'(delta_sum_q);
  assign dq_neg     = -dq_q;
  assign d_step     = div_digit(dr_q, dq_q[DIV_W-1 -: coe_pkg::DIG_W], CW'(delta_cnt_q));
  assign r_step     = div_digit(rr_q, rq_q[DIV_W-1 -: coe_pkg::DIG_W], CW'(rtt_cnt_q));

  // Evaluate jump condition and pick next step
  always_comb begin
    case (ctrl.jc)
      coe_pkg::JC_NEXT:      take_jump = 1'b0;
      coe_pkg::JC_ALWAYS:    take_jump = 1'b1;
      coe_pkg::JC_SAMPLE:    take_jump = (req_q == coe_pkg::REQ_SAMPLE);
      coe_pkg::JC_ADJ_TS:    take_jump = (req_q == coe_pkg::REQ_ADJ_TS);
      coe_pkg::JC_ADJ_DELTA: take_jump = (req_q == coe_pkg::REQ_ADJ_DELTA);
      coe_pkg::JC_UNUSED:    take_jump = !(req_q inside {coe_pkg::REQ_SAMPLE,
                                           coe_pkg::REQ_ADJ_TS, coe_pkg::REQ_ADJ_DELTA});
      coe_pkg::JC_DIV_MORE:  take_jump = (it_q != '0);
      coe_pkg::JC_OUT_BUSY:  take_jump = out_busy;
      default:               take_jump = 1'b0;
    endcase
    if (in_acc) begin
      pc_d = coe_pkg::PC_ENTRY;
    end else if (take_jump) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  // Datapath operations driven by the control word
  always_comb begin
    acc_d        = acc_q;
    res_d        = res_q;
    rtt_slot_d   = rtt_slot_q;
    delta_slot_d = delta_slot_q;
    rtt_cnt_d    = rtt_cnt_q;
    delta_cnt_d  = delta_cnt_q;
    rtt_sum_d    = rtt_sum_q;
    delta_sum_d  = delta_sum_q;
    avg_rtt_d    = avg_rtt_q;
    avg_delta_d  = avg_delta_q;
    dq_d         = dq_q;
    rq_d         = rq_q;
    dr_d         = dr_q;
    rr_d         = rr_q;
    dneg_d       = dneg_q;
    it_d         = it_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    case (ctrl.op)
      coe_pkg::OP_LD_TS:    acc_d = signed'(coe_pkg::ACC_W'(ts_q));
      coe_pkg::OP_ADD_AVGD: acc_d = acc_q + coe_pkg::ACC_W'(avg_delta_q);
      coe_pkg::OP_MUL1000:  acc_d = (acc_q <<< 10) - (acc_q <<< 4) - (acc_q <<< 3);
      coe_pkg::OP_SUB_NOW:  acc_d = signed'(coe_pkg::ACC_W'(now_q)) - acc_q;
      coe_pkg::OP_SUB_HALF: acc_d = acc_q - signed'(coe_pkg::ACC_W'(half_rtt));
      coe_pkg::OP_CLR:      acc_d = '0;
      coe_pkg::OP_DROP_OLD: begin
        // drop the entries about to be overwritten
        if (rtt_full) begin
          rtt_sum_d = rtt_sum_q - RSUM_W'(rtt_old_q);
        end
        if (delta_full) begin
          delta_sum_d = delta_sum_q - DSUM_W'(delta_old_q);
        end
      end
      coe_pkg::OP_PUSH: begin
        rtt_sum_d    = rtt_sum_q + RSUM_W'(rtt_in_q);
        delta_sum_d  = delta_sum_q + DSUM_W'(signed'(acc_q[coe_pkg::RES_W-1:0]));
        rtt_slot_d   = (rtt_slot_q == RAW'(RTT_DEPTH - 1)) ? '0 : rtt_slot_q + 1'b1;
        delta_slot_d = (delta_slot_q == DAW'(DELTA_DEPTH - 1)) ? '0 : delta_slot_q + 1'b1;
        if (!rtt_full) begin
          rtt_cnt_d = rtt_cnt_q + 1'b1;
        end
        if (!delta_full) begin
          delta_cnt_d = delta_cnt_q + 1'b1;
        end
      end
      coe_pkg::OP_DIV_LD: begin
        dneg_d = delta_sum_q[DSUM_W-1];
        dq_d   = DIV_W'(delta_mag);
        rq_d   = DIV_W'(rtt_sum_q);
        dr_d   = '0;
        rr_d   = '0;
        it_d   = ITW'(DIV_DIGITS - 1);
      end
      coe_pkg::OP_DIV_STEP: begin
        dq_d = {dq_q[DIV_W-coe_pkg::DIG_W-1:0], d_step[coe_pkg::DIG_W-1:0]};
        dr_d = d_step[CW+coe_pkg::DIG_W-1:coe_pkg::DIG_W];
        rq_d = {rq_q[DIV_W-coe_pkg::DIG_W-1:0], r_step[coe_pkg::DIG_W-1:0]};
        rr_d = r_step[CW+coe_pkg::DIG_W-1:coe_pkg::DIG_W];
        it_d = it_q - 1'b1;
      end
      coe_pkg::OP_DIV_END: begin
        // truncate toward zero: divide magnitudes, restore sign
        avg_rtt_d   = rq_q[coe_pkg::RTT_W-1:0];
        avg_delta_d = dneg_q ? signed'(dq_neg[coe_pkg::RES_W-1:0])
                             : signed'(dq_q[coe_pkg::RES_W-1:0]);
      end
      coe_pkg::OP_RES: begin
        if (acc_q > coe_pkg::RES_MAX_ACC) begin
          res_d = coe_pkg::RES_MAX_ACC[coe_pkg::RES_W-1:0];
        end else if (acc_q < coe_pkg::RES_MIN_ACC) begin
          res_d = coe_pkg::RES_MIN_ACC[coe_pkg::RES_W-1:0];
        end else begin
          res_d = acc_q[coe_pkg::RES_W-1:0];
        end
      end
      coe_pkg::OP_OUT: begin
        if (!out_busy) begin
          m_valid_d = 1'b1;
          m_data_d  = {{coe_pkg::OUT_PAD_W{1'b0}}, coe_pkg::CNT_OUT_W'(delta_cnt_q),
                       avg_delta_q, avg_rtt_q, res_q};
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= coe_pkg::PC_IDLE;
      rtt_slot_q   <= '0;
      delta_slot_q <= '0;
      rtt_cnt_q    <= '0;
      delta_cnt_q  <= '0;
      rtt_sum_q    <= '0;
      delta_sum_q  <= '0;
      avg_rtt_q    <= '0;
      avg_delta_q  <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      pc_q         <= pc_d;
      rtt_slot_q   <= rtt_slot_d;
      delta_slot_q <= delta_slot_d;
      rtt_cnt_q    <= rtt_cnt_d;
      delta_cnt_q  <= delta_cnt_d;
      rtt_sum_q    <= rtt_sum_d;
      delta_sum_q  <= delta_sum_d;
      avg_rtt_q    <= avg_rtt_d;
      avg_delta_q  <= avg_delta_d;
      m_valid_q    <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q    <= s_axis_tuser;
      now_q    <= s_axis_tdata[coe_pkg::NOW_W-1:0];
      rtt_in_q <= s_axis_tdata[coe_pkg::NOW_W +: coe_pkg::RTT_W];
      ts_q     <= s_axis_tdata[coe_pkg::NOW_W+coe_pkg::RTT_W +: coe_pkg::TS_W];
    end
    acc_q    <= acc_d;
    res_q    <= res_d;
    dq_q     <= dq_d;
    rq_q     <= rq_d;
    dr_q     <= dr_d;
    rr_q     <= rr_d;
    dneg_q   <= dneg_d;
    it_q     <= it_d;
    m_data_q <= m_data_d;
  end

  // Window memories: read oldest entry, write newest
  always_ff @(posedge clk_i) begin
    if (ctrl.op == coe_pkg::OP_RD_OLD) begin
      rtt_old_q   <= rtt_mem[rtt_slot_q];
      delta_old_q <= delta_mem[delta_slot_q];
    end
    if (ctrl.op == coe_pkg::OP_PUSH) begin
      rtt_mem[rtt_slot_q]     <= rtt_in_q;
      delta_mem[delta_slot_q] <= acc_q[coe_pkg::RES_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/coe_checker.sv =====
`timescale 1ns / 1ps
module coe_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [coe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic [coe_pkg::REQ_W-1:0]      s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [coe_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // Take one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // Return to idle as soon as a result is loaded
  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result appeared without the sequencer going idle");

  // Leave reset idle and empty
  a_reset_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid && s_axis_tready)
    else $error("wrong state after reset");

endmodule

bind clock_offset_window_estimator coe_checker u_coe_checker (.*);
